// ===== design/stun_al_pkg.sv =====
// stun_al_pkg: shared types, constants and decode functions for the stun attribute locator
// no dependencies; imported by stun_al_core and stun_attribute_locator_top

package stun_al_pkg;

	localparam int HeaderBytes = 20;
	localparam int PosW = 17;
	localparam int TypeW = 16;
	localparam int LenW = 16;
	localparam int MethodW = 12;
	localparam int ClassW = 8;

	localparam logic [TypeW-1:0] AttrIntegrity = 16'h0008;
	localparam logic [TypeW-1:0] AttrFingerprint = 16'h8028;
	localparam logic [TypeW-1:0] TypeAliasIn = 16'h0115;
	localparam logic [TypeW-1:0] TypeAliasOut = 16'h0017;
	localparam logic [TypeW-1:0] MethodMaskHi = 16'h3e00;
	localparam logic [TypeW-1:0] MethodMaskMid = 16'h00e0;
	localparam logic [TypeW-1:0] MethodMaskLo = 16'h000f;
	localparam logic [TypeW-1:0] ClassMask = 16'h0ff0;

	localparam int InDataW = 24;
	localparam int OutDataW = 56;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_STOPPED = 2'd2,
		ST_TRUNCATED = 2'd3
	} status_t;

	typedef struct packed {
		logic [ClassW-1:0] msg_class;
		logic [MethodW-1:0] msg_method;
		logic [LenW-1:0] value_length;
		logic [PosW-1:0] value_offset;
		status_t status;
	} result_t;

	function automatic logic [TypeW-1:0] map_type(input logic [TypeW-1:0] t);
		logic [TypeW-1:0] m;
		m = (t == TypeAliasIn) ? TypeAliasOut : t;
		return m;
	endfunction

	function automatic logic [MethodW-1:0] decode_method(input logic [TypeW-1:0] t);
		logic [TypeW-1:0] m;
		logic [TypeW-1:0] r;
		m = map_type(t);
		r = ((m & MethodMaskHi) >> 2) | ((m & MethodMaskMid) >> 1) | (m & MethodMaskLo);
		return r[MethodW-1:0];
	endfunction

	function automatic logic [ClassW-1:0] decode_class(input logic [TypeW-1:0] t);
		logic [TypeW-1:0] m;
		logic [TypeW-1:0] r;
		m = map_type(t);
		r = (m & ClassMask) >> 4;
		return r[ClassW-1:0];
	endfunction

endpackage

// ===== design/stun_al_core.sv =====
// stun_al_core: per-message parse state and combinational byte step with result formation
// depends on stun_al_pkg

module stun_al_core import stun_al_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       msg_byte,
	input  logic [TypeW-1:0] wanted_type,
	input  logic             last_byte,
	output logic             res_valid,
	output result_t          res
);

	logic [PosW-1:0]  pos_q, pos_d;
	logic [PosW-1:0]  tot_q, tot_d;
	logic [TypeW-1:0] tw_q, tw_d;
	logic [TypeW-1:0] key_q, key_d;
	logic [PosW-1:0]  nho_q, nho_d;
	logic [TypeW-1:0] et_q, et_d;
	logic [LenW-1:0]  el_q, el_d;
	logic             dec_q, dec_d;

	logic [PosW-1:0]  rel;
	logic             in_hdr;
	logic [LenW-1:0]  el_full;
	logic [PosW+1:0]  pad_len;
	logic [PosW+1:0]  nxt;
	logic [PosW-1:0]  tot_full;
	logic [TypeW-1:0] tw_emit;
	status_t          st;
	logic [PosW-1:0]  off;
	logic [LenW-1:0]  len;

	assign rel      = pos_q - nho_q;
	assign in_hdr   = (pos_q >= nho_q) && (rel < PosW'(4));
	assign el_full  = {el_q[15:8], msg_byte};
	assign pad_len  = ({{(PosW+2-LenW){1'b0}}, el_full} + (PosW+2)'(3)) & ~((PosW+2)'(3));
	assign nxt      = {2'b00, nho_q} + (PosW+2)'(4) + pad_len;
	assign tot_full = {1'b0, tot_q[15:8], msg_byte} + PosW'(HeaderBytes);

	always_comb begin
		pos_d = pos_q;
		tot_d = tot_q;
		tw_d = tw_q;
		key_d = key_q;
		nho_d = nho_q;
		et_d = et_q;
		el_d = el_q;
		dec_d = dec_q;
		res_valid = 1'b0;
		st = ST_NOT_FOUND;
		off = '0;
		len = '0;
		tw_emit = tw_q;
		if (step) begin
			if (!dec_q) begin
				priority if (pos_q == PosW'(0)) begin
					key_d = wanted_type;
					tw_d = {msg_byte, 8'h00};
				end else if (pos_q == PosW'(1)) begin
					tw_d = {tw_q[15:8], msg_byte};
				end else if (pos_q == PosW'(2)) begin
					tot_d = {1'b0, msg_byte, 8'h00};
				end else if (pos_q == PosW'(3)) begin
					tot_d = tot_full;
					if (nho_q >= tot_full) begin
						res_valid = 1'b1;
						st = ST_NOT_FOUND;
						dec_d = 1'b1;
					end
				end else if (in_hdr) begin
					unique case (rel[1:0])
						2'd0: et_d = {msg_byte, 8'h00};
						2'd1: et_d = {et_q[15:8], msg_byte};
						2'd2: el_d = {msg_byte, 8'h00};
						2'd3: begin
							el_d = el_full;
							if (et_q == key_q) begin
								res_valid = 1'b1;
								st = ST_FOUND;
								off = nho_q + PosW'(4);
								len = el_full;
								dec_d = 1'b1;
							end else if ((et_q == AttrIntegrity && key_q != AttrFingerprint)
								|| et_q == AttrFingerprint) begin
								res_valid = 1'b1;
								st = ST_STOPPED;
								dec_d = 1'b1;
							end else begin
								if (nxt >= {2'b00, tot_q}) begin
									res_valid = 1'b1;
									st = ST_NOT_FOUND;
									dec_d = 1'b1;
								end
								nho_d = nxt[PosW-1:0];
							end
						end
						default: et_d = et_q;
					endcase
				end else begin
					tw_d = tw_q;
				end
				if (!dec_d) begin
					pos_d = pos_q + PosW'(1);
				end
			end
			tw_emit = tw_d;
			if (last_byte) begin
				if (!dec_d) begin
					res_valid = 1'b1;
					st = ST_TRUNCATED;
				end
				pos_d = '0;
				tot_d = '0;
				tw_d = '0;
				key_d = '0;
				nho_d = PosW'(HeaderBytes);
				et_d = '0;
				el_d = '0;
				dec_d = 1'b0;
			end
		end
	end

	always_comb begin
		res.status = st;
		res.value_offset = off;
		res.value_length = len;
		res.msg_method = decode_method(tw_emit);
		res.msg_class = decode_class(tw_emit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			tot_q <= '0;
			tw_q <= '0;
			key_q <= '0;
			nho_q <= PosW'(HeaderBytes);
			et_q <= '0;
			el_q <= '0;
			dec_q <= 1'b0;
		end else begin
			pos_q <= pos_d;
			tot_q <= tot_d;
			tw_q <= tw_d;
			key_q <= key_d;
			nho_q <= nho_d;
			et_q <= et_d;
			el_q <= el_d;
			dec_q <= dec_d;
		end
	end

	// a decided message gives nothing more until its final byte
	a_quiet_after_decision: assert property (@(posedge clk) disable iff (!arst_n)
		step && dec_q |-> !res_valid)
		else $error("result after decision");

	// final byte always restarts the message
	a_restart_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte |=> pos_q == '0 && !dec_q && nho_q == PosW'(HeaderBytes))
		else $error("no restart after final byte");

	// an undecided walk never points a header into the fixed header
	a_header_floor: assert property (@(posedge clk) disable iff (!arst_n)
		!dec_q |-> nho_q >= PosW'(HeaderBytes))
		else $error("header offset below fixed header");

	// a found entry header always sits past the fixed header
	a_found_offset: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_FOUND |-> nho_q >= PosW'(HeaderBytes))
		else $error("found offset inside fixed header");

endmodule

// ===== design/stun_attribute_locator_top.sv =====
// stun_attribute_locator_top: input register, parse core and result register on stream ports
// depends on stun_al_pkg and stun_al_core
// output: a result is registered in the result register when the byte that decides it steps the core
// throughput: one item per cycle; the input register steps the core whenever the result
// register is empty or being taken, so only a stalled result holds the input side
// reset: arst_n clears both register valids and the parse state to the start of a message

module stun_attribute_locator_top import stun_al_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [InDataW-1:0]  s_axis_tdata,   // msg_byte, wanted_type
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OutDataW-1:0] m_axis_tdata    // status, value_offset, value_length, msg_method, msg_class, zero pad
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic [TypeW-1:0]   wanted_s1;
	logic               last_s1;
	logic               advance;
	logic               res_valid;
	result_t            res;
	logic               out_valid_q;
	result_t            out_q;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata[7:0];
			wanted_s1 <= s_axis_tdata[23:8];
			last_s1 <= s_axis_tlast;
		end
	end

	stun_al_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.msg_byte    (byte_s1),
		.wanted_type (wanted_s1),
		.last_byte   (last_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {1'b0, out_q.msg_class, out_q.msg_method, out_q.value_length,
		out_q.value_offset, out_q.status};

endmodule
